// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define MDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define MDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mdl_pkg.sv
`default_nettype none

package mdl_pkg;

    localparam int FBITS   = 24;
    localparam int X_W     = 27;
    localparam int K_W     = 26;
    localparam int G_W     = 27;
    localparam int P2_W    = 28;
    localparam int P3_W    = 29;
    localparam int P5_W    = 31;
    localparam int P7_W    = 33;
    localparam int T1_W    = 27;
    localparam int T3_W    = 29;
    localparam int T5_W    = 31;
    localparam int T7_W    = 35;
    localparam int ACC_W   = 36;
    localparam int CLIP_W  = FBITS + 2;
    localparam int NSTG    = 11;

    localparam logic signed [K_W-1:0] DEADBAND_Q = 26'sd1375732;
    localparam logic signed [K_W-1:0] RESCALE_Q  = 26'sd18275834;
    localparam logic signed [K_W-1:0] K7_Q       = 26'sd29926831;
    localparam logic signed [K_W-1:0] K5_Q       = -26'sd24311949;
    localparam logic signed [K_W-1:0] K3_Q       = 26'sd4803481;
    localparam logic signed [K_W-1:0] K1_Q       = 26'sd5125728;
    localparam logic signed [K_W-1:0] SMALL_Q    = 26'sd16777;
    localparam logic signed [K_W-1:0] ONE_Q      = 26'sd16777216;

endpackage

`default_nettype wire

// File: hdl/mdl_rmul.sv
`default_nettype none

module mdl_rmul
    import mdl_pkg::*;
#(
    parameter int A_W = 27,
    parameter int B_W = 26,
    parameter int P_W = 27
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0]      p
);

    localparam int M_W = A_W + B_W;
    localparam logic signed [M_W-1:0] HALF =
        {{(M_W - FBITS){1'b0}}, 1'b1, {(FBITS - 1){1'b0}}};

    logic signed [M_W-1:0] prod;
    logic signed [M_W-1:0] rnd;
    logic signed [P_W-1:0] p_next;
    logic signed [P_W-1:0] p_reg;

    // round to nearest, ties away from zero
    assign prod   = M_W'(a) * M_W'(b);
    assign rnd    = prod + HALF - M_W'(prod[M_W-1]);
    assign p_next = rnd[P_W+FBITS-1:FBITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: hdl/motor_drive_linearizer.sv
// motor_drive_linearizer
// Maps a requested motor speed to a linearized drive command.
// Input channel s_*: one word per speed sample, requested_speed signed with
//   SAMPLE_WIDTH-2 fraction bits in the low bits of s_tdata.
// Output channel m_*: one word per sample, drive_command in the same format,
//   saturated to -1.0 .. 1.0.
// Throughput: one word per cycle while m_tready stays high; every input word
//   gives exactly one output word, in order.
// Pipeline: eleven register stages (input scaling, deadband removal, rounded
//   multiplies for g, g^2, g^3, g^5, g^7 and the coefficient products, then
//   sum, deadband restore and clip, and output rounding).
// Stall: when m_tready is low the last stage holds its word; earlier stages
//   keep advancing into empty slots, so s_tready drops only once every stage
//   holds a word. Nothing is lost or repeated.
// Reset: rst_n clears all stage valid bits; the data registers are not reset,
//   and the block accepts input as soon as reset is released.
`default_nettype none
`include "assert_macros.svh"

module motor_drive_linearizer
    import mdl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // requested_speed
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata   // drive_command
);

    localparam int UP = FBITS + 2 - SAMPLE_WIDTH;
    localparam logic signed [SAMPLE_WIDTH-1:0] ONE_OUT =
        {2'b01, {(SAMPLE_WIDTH - 2){1'b0}}};

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    logic signed [SAMPLE_WIDTH-1:0] samp;
    logic signed [X_W-1:0]          x_next;
    logic signed [X_W-1:0]          x_reg;
    logic signed [X_W-1:0]          d_next;
    logic signed [X_W-1:0]          d_reg;
    logic signed [G_W-1:0]          g;
    logic signed [G_W-1:0]          g3_reg;
    logic signed [P2_W-1:0]         p2;
    logic signed [P2_W-1:0]         p2_4_reg;
    logic signed [P2_W-1:0]         p2_5_reg;
    logic signed [P3_W-1:0]         p3;
    logic signed [P5_W-1:0]         p5;
    logic signed [P7_W-1:0]         p7;
    logic signed [T1_W-1:0]         t1;
    logic signed [T1_W-1:0]         t1_5_reg;
    logic signed [T3_W-1:0]         t3;
    logic signed [T5_W-1:0]         t5;
    logic signed [T7_W-1:0]         t7;
    logic signed [ACC_W-1:0]        s13_reg;
    logic signed [ACC_W-1:0]        s135_reg;
    logic signed [ACC_W-1:0]        sum_reg;
    logic signed [ACC_W-1:0]        adj;
    logic signed [CLIP_W-1:0]       clip_next;
    logic signed [CLIP_W-1:0]       clip_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    // advance chain: a stage loads when it is empty or its word moves on
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTG-1];

    assign samp = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    if (UP >= 0)
    begin : g_in_up
        assign x_next = X_W'(samp) <<< UP;
    end
    else
    begin : g_in_dn
        localparam int DN  = -UP;
        localparam int SW1 = SAMPLE_WIDTH + 1;
        logic signed [SW1-1:0] in_rnd;
        assign in_rnd = SW1'(samp) + SW1'(1 << (DN - 1)) - SW1'(samp[SAMPLE_WIDTH-1]);
        assign x_next = X_W'(in_rnd >>> DN);
    end

    always_comb
    begin
        priority if (x_reg > X_W'(DEADBAND_Q))
        begin
            d_next = x_reg - X_W'(DEADBAND_Q);
        end
        else if (x_reg < -X_W'(DEADBAND_Q))
        begin
            d_next = x_reg + X_W'(DEADBAND_Q);
        end
        else
        begin
            d_next = '0;
        end
    end

    always_comb
    begin
        priority if (sum_reg > ACC_W'(SMALL_Q))
        begin
            adj = sum_reg + ACC_W'(DEADBAND_Q);
        end
        else if (sum_reg < -ACC_W'(SMALL_Q))
        begin
            adj = sum_reg - ACC_W'(DEADBAND_Q);
        end
        else
        begin
            adj = sum_reg;
        end
    end

    always_comb
    begin
        priority if (adj > ACC_W'(ONE_Q))
        begin
            clip_next = CLIP_W'(ONE_Q);
        end
        else if (adj < -ACC_W'(ONE_Q))
        begin
            clip_next = -CLIP_W'(ONE_Q);
        end
        else
        begin
            clip_next = CLIP_W'(adj);
        end
    end

    if (UP > 0)
    begin : g_out_dn
        logic signed [CLIP_W-1:0] o_rnd;
        assign o_rnd    = clip_reg + CLIP_W'(1 << (UP - 1)) - CLIP_W'(clip_reg[CLIP_W-1]);
        assign out_next = o_rnd[CLIP_W-1:UP];
    end
    else
    begin : g_out_up
        localparam int DNO = -UP;
        assign out_next = SAMPLE_WIDTH'(clip_reg) <<< DNO;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_reg <= x_next;
        end
        if (adv[1])
        begin
            d_reg <= d_next;
        end
        if (adv[3])
        begin
            g3_reg <= g;
        end
        if (adv[4])
        begin
            p2_4_reg <= p2;
        end
        if (adv[5])
        begin
            p2_5_reg <= p2_4_reg;
            t1_5_reg <= t1;
        end
        if (adv[6])
        begin
            s13_reg <= ACC_W'(t1_5_reg) + ACC_W'(t3);
        end
        if (adv[7])
        begin
            s135_reg <= s13_reg + ACC_W'(t5);
        end
        if (adv[8])
        begin
            sum_reg <= s135_reg + ACC_W'(t7);
        end
        if (adv[9])
        begin
            clip_reg <= clip_next;
        end
        if (adv[10])
        begin
            out_reg <= out_next;
        end
    end

    mdl_rmul #(.A_W(X_W), .B_W(K_W), .P_W(G_W)) u_mul_g (
        .clk (clk), .en (adv[2]), .a (d_reg), .b (RESCALE_Q), .p (g)
    );

    mdl_rmul #(.A_W(G_W), .B_W(G_W), .P_W(P2_W)) u_mul_p2 (
        .clk (clk), .en (adv[3]), .a (g), .b (g), .p (p2)
    );

    mdl_rmul #(.A_W(P2_W), .B_W(G_W), .P_W(P3_W)) u_mul_p3 (
        .clk (clk), .en (adv[4]), .a (p2), .b (g3_reg), .p (p3)
    );

    mdl_rmul #(.A_W(G_W), .B_W(K_W), .P_W(T1_W)) u_mul_t1 (
        .clk (clk), .en (adv[4]), .a (g3_reg), .b (K1_Q), .p (t1)
    );

    mdl_rmul #(.A_W(P3_W), .B_W(P2_W), .P_W(P5_W)) u_mul_p5 (
        .clk (clk), .en (adv[5]), .a (p3), .b (p2_4_reg), .p (p5)
    );

    mdl_rmul #(.A_W(P3_W), .B_W(K_W), .P_W(T3_W)) u_mul_t3 (
        .clk (clk), .en (adv[5]), .a (p3), .b (K3_Q), .p (t3)
    );

    mdl_rmul #(.A_W(P5_W), .B_W(P2_W), .P_W(P7_W)) u_mul_p7 (
        .clk (clk), .en (adv[6]), .a (p5), .b (p2_5_reg), .p (p7)
    );

    mdl_rmul #(.A_W(P5_W), .B_W(K_W), .P_W(T5_W)) u_mul_t5 (
        .clk (clk), .en (adv[6]), .a (p5), .b (K5_Q), .p (t5)
    );

    mdl_rmul #(.A_W(P7_W), .B_W(K_W), .P_W(T7_W)) u_mul_t7 (
        .clk (clk), .en (adv[7]), .a (p7), .b (K7_Q), .p (t7)
    );

    always_comb
    begin
        m_tdata                   = '0;
        m_tdata[SAMPLE_WIDTH-1:0] = out_reg;
    end

    `MDL_ASSERT_SAME(a_out_range, m_tvalid, (out_reg <= ONE_OUT) && (out_reg >= -ONE_OUT), "drive command outside -1.0 .. 1.0")
    `MDL_ASSERT_SAME(a_ready_flow, m_tready, s_tready, "input stalled while output drains")
    `MDL_ASSERT_NEXT(a_last_fill, vld_reg[NSTG-2] && adv[NSTG-1], m_tvalid, "word lost before output stage")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mdl_pkg::*;

    localparam int SW        = 16;
    localparam int DW        = ((SW + 7) / 8) * 8;
    localparam int IN_FRAC   = SW - 2;
    localparam int N_RANDOM  = 880;
    localparam int STALL_MAX = 4000;
    localparam int DRAIN_CYC = 24;

    class drive_checker;
        logic [SW-1:0] expected_drive[$];
        int            errors;
        int            printed;

        function automatic longint round_away(longint v, int n);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) << (n - 1))) >>> n;
            return (v < 0) ? -m : m;
        endfunction

        function automatic longint fmul(longint a, longint b);
            return round_away(a * b, FBITS);
        endfunction

        function automatic logic [SW-1:0] linearize(logic signed [SW-1:0] speed);
            longint x, g, g2, g3, g5, g7, acc;
            int     up;
            up = FBITS - IN_FRAC;
            x  = longint'(speed);
            if (up >= 0)
                x = x <<< up;
            else
                x = round_away(x, -up);
            if (x > longint'(DEADBAND_Q))
                g = x - longint'(DEADBAND_Q);
            else if (x < -longint'(DEADBAND_Q))
                g = x + longint'(DEADBAND_Q);
            else
                g = 0;
            g  = fmul(g, longint'(RESCALE_Q));
            g2 = fmul(g, g);
            g3 = fmul(g2, g);
            g5 = fmul(g3, g2);
            g7 = fmul(g5, g2);
            acc = fmul(longint'(K7_Q), g7) + fmul(longint'(K5_Q), g5)
                + fmul(longint'(K3_Q), g3) + fmul(longint'(K1_Q), g);
            if (acc > longint'(SMALL_Q))
                acc = acc + longint'(DEADBAND_Q);
            else if (acc < -longint'(SMALL_Q))
                acc = acc - longint'(DEADBAND_Q);
            if (acc > longint'(ONE_Q))
                acc = longint'(ONE_Q);
            if (acc < -longint'(ONE_Q))
                acc = -longint'(ONE_Q);
            if (up >= 0)
                acc = round_away(acc, up);
            else
                acc = acc <<< (-up);
            return acc[SW-1:0];
        endfunction

        task report(string msg);
            errors++;
            if (printed < 40)
            begin
                printed++;
                $display("%0t mismatch: %s", $realtime, msg);
            end
        endtask

        function void note_speed(logic signed [SW-1:0] speed);
            expected_drive.push_back(linearize(speed));
        endfunction

        task check_drive(logic [SW-1:0] drive_command);
            logic [SW-1:0] want;
            if (expected_drive.size() == 0)
            begin
                report($sformatf("unexpected drive_command %0d", $signed(drive_command)));
            end
            else
            begin
                want = expected_drive.pop_front();
                if (drive_command !== want)
                    report($sformatf("drive_command got %0d want %0d",
                                     $signed(drive_command), $signed(want)));
            end
        endtask

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;

    logic          idle_on = 1'b0;
    int            quiet_cycles = 0;
    drive_checker  board = new();

    motor_drive_linearizer #(
        .SAMPLE_WIDTH (SW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_speed(input logic signed [SW-1:0] speed);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DW - SW){1'b0}}, speed};
        do @(posedge clk); while (!s_tready);
        board.note_speed(speed);
    endtask

    task automatic take_drive_words();
        int gap;
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid)
                board.check_drive(m_tdata[SW-1:0]);
        end
    endtask

    function automatic logic signed [SW-1:0] pick_speed();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = SW'($urandom_range(0, (1 << SW) - 1));
            2, 3:    v = SW'($urandom_range(1300, 1500));
            default: v = SW'(int'($urandom_range(0, 32768)) - 16384);
        endcase
        if ($urandom_range(0, 1) == 1 && v != -(1 <<< (SW - 1)))
            v = -v;
        return v;
    endfunction

    initial
    begin
        logic signed [SW-1:0] directed[$];
        int i;
        directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd1343, -16'sd1343, 16'sd1344,
                     -16'sd1344, 16'sd1388, 16'sd1392, 16'sd1396, -16'sd1392,
                     16'sd8192, -16'sd8192, 16'sd16383, 16'sd16384, -16'sd16384,
                     16'sd20000, -16'sd20000, 16'sd32767, -16'sd32768,
                     16'sh5555, 16'shaaaa};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        fork
            take_drive_words();
        join_none
        foreach (directed[k])
            send_speed(directed[k]);
        idle_on <= 1'b1;
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == 250)
            begin
                // hold input until the pipeline has fully drained
                s_tvalid <= 1'b0;
                while (board.pending() != 0) @(posedge clk);
            end
            if (i == 400)
                idle_on <= 1'b0;
            if (i == 550)
                idle_on <= 1'b1;
            if (i == 760)
                idle_on <= 1'b0;
            send_speed(pick_speed());
        end
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
